>>> design/mlb_pkg.sv
// Package for the multi-LED blink controller: request codes, register map,
// mode codes and the command/status/config structs shared between the modules.
// No dependencies.
`default_nettype none

package mlb_pkg;

  localparam int NUM_LEDS_DEF = 8;
  localparam int GEN_NUM      = 3;
  localparam int TIME_W       = 8;
  localparam int LEVELS_W     = 8;
  localparam int IDX_W        = 3;
  localparam int MODE_W       = 2;
  localparam int APB_ADDR_W   = 5;
  localparam int APB_DATA_W   = 32;
  localparam int REG_IDX_W    = 3;

  typedef enum logic [1:0] {
    REQ_UPDATE = 2'd0,
    REQ_SET    = 2'd1,
    REQ_TOGGLE = 2'd2,
    REQ_MODE   = 2'd3
  } mlb_req_e;

  localparam logic [MODE_W-1:0] MODE_STEADY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GEN1   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GEN2   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_GEN3   = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_ON_GEN1   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFF_GEN1  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ON_GEN2   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFF_GEN2  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ON_GEN3   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OFF_GEN3  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LEVEL_MSK = 3'd6;

  typedef struct packed {
    logic [GEN_NUM-1:0][TIME_W-1:0] on_time;
    logic [GEN_NUM-1:0][TIME_W-1:0] off_time;
    logic [LEVELS_W-1:0]            on_level_mask;
  } mlb_cfg_t;

  typedef struct packed {
    logic exec;      // apply the accepted request to the LED/generator state
    logic load_out;  // capture LED levels into the output register
  } mlb_cmd_t;

  typedef struct packed {
    logic is_update;
  } mlb_sts_t;

endpackage

`default_nettype wire

>>> design/mlb_if.sv
// Handshake channels of the blink controller: request in, LED levels out.
// Depends on mlb_pkg.
`default_nettype none

interface mlb_req_if
  import mlb_pkg::*;
();
  logic                valid;
  logic                ready;
  mlb_req_e            req_type;
  logic [IDX_W-1:0]    led_index;
  logic                light_value;
  logic [MODE_W-1:0]   blink_mode;
  logic                invert_phase;
  logic [TIME_W-1:0]   current_time;

  modport source (output valid, req_type, led_index, light_value, blink_mode,
                  invert_phase, current_time, input ready);
  modport sink   (input valid, req_type, led_index, light_value, blink_mode,
                  invert_phase, current_time, output ready);
endinterface

interface mlb_res_if
  import mlb_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [LEVELS_W-1:0] led_levels;

  modport source (output valid, led_levels, input ready);
  modport sink   (input valid, led_levels, output ready);
endinterface

`default_nettype wire

>>> design/mlb_regs.sv
// APB register file: blink generator thresholds and the lit-level mask.
// Depends on mlb_pkg.
`default_nettype none

module mlb_regs
  import mlb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output      logic [APB_DATA_W-1:0] prdata,
  output      logic                  pready,
  output      mlb_cfg_t              cfg_o
);

  mlb_cfg_t                cfg_q, cfg_d;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic [TIME_W-1:0]       wr_byte;
  logic                    wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_byte = pwdata[TIME_W-1:0];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ON_GEN1:   cfg_d.on_time[0]    = wr_byte;
        REG_OFF_GEN1:  cfg_d.off_time[0]   = wr_byte;
        REG_ON_GEN2:   cfg_d.on_time[1]    = wr_byte;
        REG_OFF_GEN2:  cfg_d.off_time[1]   = wr_byte;
        REG_ON_GEN3:   cfg_d.on_time[2]    = wr_byte;
        REG_OFF_GEN3:  cfg_d.off_time[2]   = wr_byte;
        REG_LEVEL_MSK: cfg_d.on_level_mask = wr_byte;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ON_GEN1:   prdata = APB_DATA_W'(cfg_q.on_time[0]);
      REG_OFF_GEN1:  prdata = APB_DATA_W'(cfg_q.off_time[0]);
      REG_ON_GEN2:   prdata = APB_DATA_W'(cfg_q.on_time[1]);
      REG_OFF_GEN2:  prdata = APB_DATA_W'(cfg_q.off_time[1]);
      REG_ON_GEN3:   prdata = APB_DATA_W'(cfg_q.on_time[2]);
      REG_OFF_GEN3:  prdata = APB_DATA_W'(cfg_q.off_time[2]);
      REG_LEVEL_MSK: prdata = APB_DATA_W'(cfg_q.on_level_mask);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_time       <= '0;
      cfg_q.off_time      <= '0;
      cfg_q.on_level_mask <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> design/mlb_ctrl.sv
// Controller: request acceptance and the output register occupancy FSM.
// Depends on mlb_pkg; drives commands to mlb_dp.
`default_nettype none

module mlb_ctrl
  import mlb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output      logic     req_ready_o,
  output      logic     res_valid_o,
  input  wire logic     res_ready_i,
  input  wire mlb_sts_t sts_i,
  output      mlb_cmd_t cmd_o
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_q, state_d;
  logic accept;

  // Take a new request whenever the output slot is free or drains this cycle.
  assign req_ready_o = (state_q == ST_EMPTY) || res_ready_i;
  assign accept      = req_valid_i && req_ready_o;
  assign res_valid_o = (state_q == ST_FULL);

  assign cmd_o.exec     = accept;
  assign cmd_o.load_out = accept && sts_i.is_update;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (cmd_o.load_out) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (cmd_o.load_out) state_d = ST_FULL;
        else if (res_ready_i) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/mlb_dp.sv
// Datapath: three blink generators, per-LED level/mode/invert state and the
// LED level output register. Depends on mlb_pkg; commanded by mlb_ctrl.
`default_nettype none

module mlb_dp
  import mlb_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mlb_cfg_t            cfg_i,
  input  wire mlb_req_e            req_type_i,
  input  wire logic [IDX_W-1:0]    led_index_i,
  input  wire logic                light_value_i,
  input  wire logic [MODE_W-1:0]   blink_mode_i,
  input  wire logic                invert_phase_i,
  input  wire logic [TIME_W-1:0]   current_time_i,
  input  wire mlb_cmd_t            cmd_i,
  output      mlb_sts_t            sts_o,
  output      logic [LEVELS_W-1:0] led_levels_o
);

  logic [GEN_NUM-1:0]             phase_q, phase_adv;
  logic [GEN_NUM-1:0][TIME_W-1:0] start_q;
  logic [GEN_NUM-1:0]             fire;

  logic [NUM_LEDS-1:0]             level_q, level_d;
  logic [NUM_LEDS-1:0][MODE_W-1:0] mode_q, mode_d;
  logic [NUM_LEDS-1:0]             invert_q, invert_d;

  logic [LEVELS_W-1:0] levels_next;
  logic [LEVELS_W-1:0] led_levels_q;
  logic                lit;
  logic                do_update;

  assign sts_o.is_update = (req_type_i == REQ_UPDATE);
  assign do_update       = cmd_i.exec && sts_o.is_update;
  assign lit             = cfg_i.on_level_mask[led_index_i];

  // Toggle a generator once the wrapped elapsed time passes its phase limit.
  always_comb begin
    for (int g = 0; g < GEN_NUM; g++) begin
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] limit;
      elapsed      = current_time_i - start_q[g];
      limit        = phase_q[g] ? cfg_i.on_time[g] : cfg_i.off_time[g];
      fire[g]      = (elapsed > limit);
      phase_adv[g] = phase_q[g] ^ fire[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      start_q <= '0;
    end else if (do_update) begin
      phase_q <= phase_adv;
      for (int g = 0; g < GEN_NUM; g++) begin
        if (fire[g]) start_q[g] <= current_time_i;
      end
    end
  end

  // Per-LED writes; an index past the last LED matches nothing.
  always_comb begin
    level_d  = level_q;
    mode_d   = mode_q;
    invert_d = invert_q;
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (cmd_i.exec && (int'(led_index_i) == i)) begin
        unique case (req_type_i)
          REQ_SET:    level_d[i] = light_value_i ^ ~lit;
          REQ_TOGGLE: level_d[i] = ~level_q[i];
          REQ_MODE: begin
            mode_d[i]   = blink_mode_i;
            invert_d[i] = invert_phase_i;
          end
          REQ_UPDATE: level_d[i] = level_q[i];
          default:    level_d[i] = level_q[i];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      mode_q   <= '0;
      invert_q <= '0;
    end else begin
      level_q  <= level_d;
      mode_q   <= mode_d;
      invert_q <= invert_d;
    end
  end

  for (genvar gi = 0; gi < LEVELS_W; gi++) begin : g_out
    if (gi < NUM_LEDS) begin : g_led
      logic src;
      always_comb begin
        unique case (mode_q[gi])
          MODE_STEADY: src = 1'b1;
          MODE_GEN1:   src = phase_adv[0];
          MODE_GEN2:   src = phase_adv[1];
          MODE_GEN3:   src = phase_adv[2];
          default:     src = 1'b1;
        endcase
      end
      assign levels_next[gi] = (src ^ invert_q[gi]) & level_q[gi];
    end else begin : g_absent
      assign levels_next[gi] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_levels_q <= '0;
    end else if (cmd_i.load_out) begin
      led_levels_q <= levels_next;
    end
  end

  assign led_levels_o = led_levels_q;

endmodule

`default_nettype wire

>>> design/multi_led_blink_controller.sv
// Multi-LED blink controller: three blink generators and per-LED state,
// driven by requests, with LED pin levels returned on each update.
// Channels: req_i sink (valid/ready) takes one request per cycle; res_o
// source returns the 8-bit pin levels for every update request, nothing for
// set, toggle or mode requests. An APB port programs the on/off thresholds
// (byte addresses 0..20) and the lit-level mask (address 24); pready is tied
// high and writes land on the access cycle.
// Latency: an update's result is valid on res_o the cycle after the request
// is accepted. Throughput: one request per cycle, set by the single output
// register; a new request is taken in the same cycle the held result drains.
// Reset (rst_ni low, asynchronous): generators off with start time zero, all
// LEDs off in steady mode, thresholds zero, lit mask all ones.
// Stall: while res_o is held by the receiver, the result stays stable and
// req_i.ready drops, so no further request is taken until it drains.
// Depends on mlb_pkg, mlb_if, mlb_regs, mlb_ctrl and mlb_dp.
`default_nettype none

module multi_led_blink_controller
  import mlb_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  mlb_req_if.sink                    req_i,
  mlb_res_if.source                  res_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output      logic [APB_DATA_W-1:0] prdata,
  output      logic                  pready
);

  mlb_cfg_t cfg;
  mlb_cmd_t cmd;
  mlb_sts_t sts;

  mlb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mlb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mlb_dp #(
    .NUM_LEDS (NUM_LEDS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .req_type_i     (req_i.req_type),
    .led_index_i    (req_i.led_index),
    .light_value_i  (req_i.light_value),
    .blink_mode_i   (req_i.blink_mode),
    .invert_phase_i (req_i.invert_phase),
    .current_time_i (req_i.current_time),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .led_levels_o   (res_o.led_levels)
  );

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Testbench for multi_led_blink_controller: directed script, then randomized requests
// checked against a behavioral blink predictor. Uses mlb_pkg and the mlb_if channels.
`timescale 1ns / 1ps

module tb_top;
  import mlb_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int SCRIPT_LEN = 23;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 172;

  typedef struct packed {
    mlb_req_e            kind;
    logic [IDX_W-1:0]    led;
    logic                light;
    logic [MODE_W-1:0]   mode;
    logic                inv;
    logic [TIME_W-1:0]   now;
  } blink_req_t;

  typedef struct packed {
    blink_req_t          rq;
    logic                fixed;
    logic [LEVELS_W-1:0] fixed_levels;
  } script_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;

  mlb_req_if req_ch ();
  mlb_res_if res_ch ();

  multi_led_blink_controller uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of thresholds, lit mask and LED/generator state
  logic [TIME_W-1:0]   on_thr [GEN_NUM]        = '{default: '0};
  logic [TIME_W-1:0]   off_thr [GEN_NUM]       = '{default: '0};
  logic [LEVELS_W-1:0] lit_mask                = '1;
  logic                gen_ph [GEN_NUM]        = '{default: 1'b0};
  logic [TIME_W-1:0]   gen_t0 [GEN_NUM]        = '{default: '0};
  logic                led_lvl [NUM_LEDS_DEF]  = '{default: 1'b0};
  logic [MODE_W-1:0]   led_mode [NUM_LEDS_DEF] = '{default: MODE_STEADY};
  logic                led_inv [NUM_LEDS_DEF]  = '{default: 1'b0};

  logic [LEVELS_W-1:0] levels_due [$];
  logic [TIME_W-1:0]   wall_time = '0;
  int mismatch_cnt = 0;
  int tx_max = 15;
  int rx_max = 15;
  int rx_wait = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void blink_predict(input blink_req_t r, output bit has_res,
                                        output logic [LEVELS_W-1:0] lv);
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] limit;
    logic src;
    int g, i;
    has_res = 1'b0;
    lv = '0;
    case (r.kind)
      REQ_UPDATE: begin
        for (g = 0; g < GEN_NUM; g++) begin
          elapsed = r.now - gen_t0[g];
          limit = gen_ph[g] ? on_thr[g] : off_thr[g];
          if (elapsed > limit) begin
            gen_ph[g] = ~gen_ph[g];
            gen_t0[g] = r.now;
          end
        end
        for (i = 0; i < NUM_LEDS_DEF; i++) begin
          src = (led_mode[i] == MODE_STEADY) ? 1'b1 : gen_ph[led_mode[i] - MODE_GEN1];
          lv[i] = (src ^ led_inv[i]) & led_lvl[i];
        end
        has_res = 1'b1;
      end
      // a set stores the pin level, so flip it where the LED lights low
      REQ_SET:    led_lvl[r.led] = r.light ^ ~lit_mask[r.led];
      REQ_TOGGLE: led_lvl[r.led] = ~led_lvl[r.led];
      default: begin
        led_mode[r.led] = r.mode;
        led_inv[r.led] = r.inv;
      end
    endcase
  endfunction

  function automatic void cfg_apply(input logic [REG_IDX_W-1:0] idx,
                                    input logic [TIME_W-1:0] v);
    case (idx)
      REG_ON_GEN1:   on_thr[0] = v;
      REG_OFF_GEN1:  off_thr[0] = v;
      REG_ON_GEN2:   on_thr[1] = v;
      REG_OFF_GEN2:  off_thr[1] = v;
      REG_ON_GEN3:   on_thr[2] = v;
      REG_OFF_GEN3:  off_thr[2] = v;
      REG_LEVEL_MSK: lit_mask = v;
      default: ;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_threshold(input int ph);
    if (ph == 0) return '1;
    if (ph == 1) return '0;
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return TIME_W'($urandom_range(0, 255));
      default: return TIME_W'($urandom_range(0, 6));
    endcase
  endfunction

  function automatic blink_req_t rand_req();
    blink_req_t r;
    int pick;
    pick = $urandom_range(0, 9);
    r.kind = (pick < 4) ? REQ_UPDATE : (pick < 6) ? REQ_SET :
             (pick < 8) ? REQ_TOGGLE : REQ_MODE;
    r.led = IDX_W'($urandom_range(0, 7));
    r.light = 1'($urandom_range(0, 1));
    r.mode = MODE_W'($urandom_range(0, 3));
    r.inv = 1'($urandom_range(0, 1));
    r.now = TIME_W'($urandom_range(0, 255));
    // updates mostly follow a slowly running clock so the generators cycle
    if (r.kind == REQ_UPDATE) begin
      if ($urandom_range(0, 15) == 0) wall_time = TIME_W'($urandom_range(0, 255));
      else wall_time = wall_time + TIME_W'($urandom_range(0, 3));
      r.now = wall_time;
    end
    return r;
  endfunction

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [TIME_W-1:0] v);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = {24'($urandom), v};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_apply(idx, v);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input blink_req_t r, input logic fixed,
                          input logic [LEVELS_W-1:0] fixed_lv);
    int gap;
    bit has_res;
    logic [LEVELS_W-1:0] lv;
    gap = (tx_max > 0) ? $urandom_range(0, tx_max) : 0;
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.req_type = r.kind;
    req_ch.led_index = r.led;
    req_ch.light_value = r.light;
    req_ch.blink_mode = r.mode;
    req_ch.invert_phase = r.inv;
    req_ch.current_time = r.now;
    req_ch.valid = 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
    blink_predict(r, has_res, lv);
    if (has_res) levels_due.push_back(fixed ? fixed_lv : lv);
    @(negedge clk_i);
  endtask

  task automatic drain_to_idle();
    req_ch.valid = 1'b0;
    while (levels_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Receiver: hold ready low for a drawn number of cycles after each result
  always @(negedge clk_i) begin
    if (rx_wait > 0) begin
      res_ch.ready = 1'b0;
      rx_wait--;
    end else begin
      res_ch.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    logic [LEVELS_W-1:0] want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (levels_due.size() == 0) begin
        $error("led_levels: no result expected, got %02h", res_ch.led_levels);
        mismatch_cnt++;
      end else begin
        want = levels_due.pop_front();
        if (res_ch.led_levels !== want) begin
          $error("led_levels: expected %02h, actual %02h", want, res_ch.led_levels);
          mismatch_cnt++;
        end
      end
      rx_wait = (rx_max > 0) ? $urandom_range(0, rx_max) : 0;
    end
  end

  initial begin
    script_row_t script [SCRIPT_LEN];
    int k, ph, n;
    script = '{
      '{'{REQ_UPDATE, 3'd0, 1'b0, MODE_STEADY, 1'b0, 8'h00}, 1'b1, 8'h00},
      '{'{REQ_SET,    3'd0, 1'b1, MODE_STEADY, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{REQ_SET,    3'd7, 1'b1, MODE_STEADY, 1'b0, 8'hFF}, 1'b0, 8'h00},
      '{'{REQ_UPDATE, 3'd0, 1'b0, MODE_STEADY, 1'b0, 8'h00}, 1'b1, 8'h81},
      '{'{REQ_MODE,   3'd0, 1'b0, MODE_GEN1,   1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{REQ_MODE,   3'd7, 1'b1, MODE_GEN3,   1'b1, 8'h00}, 1'b0, 8'h00},
      '{'{REQ_UPDATE, 3'd0, 1'b0, MODE_STEADY, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{REQ_UPDATE, 3'd7, 1'b1, MODE_GEN3,   1'b1, 8'h01}, 1'b0, 8'h00},
      '{'{REQ_TOGGLE, 3'd3, 1'b0, MODE_STEADY, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{REQ_MODE,   3'd3, 1'b0, MODE_GEN2,   1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{REQ_UPDATE, 3'd0, 1'b0, MODE_STEADY, 1'b0, 8'hFF}, 1'b0, 8'h00},
      '{'{REQ_SET,    3'd5, 1'b0, MODE_STEADY, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{REQ_MODE,   3'd1, 1'b0, MODE_STEADY, 1'b1, 8'h00}, 1'b0, 8'h00},
      '{'{REQ_SET,    3'd1, 1'b1, MODE_STEADY, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{REQ_UPDATE, 3'd0, 1'b0, MODE_STEADY, 1'b0, 8'hFF}, 1'b0, 8'h00},
      '{'{REQ_TOGGLE, 3'd7, 1'b0, MODE_STEADY, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{REQ_TOGGLE, 3'd7, 1'b0, MODE_STEADY, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{REQ_SET,    3'd6, 1'b1, MODE_STEADY, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{REQ_MODE,   3'd6, 1'b0, MODE_GEN3,   1'b1, 8'h00}, 1'b0, 8'h00},
      '{'{REQ_UPDATE, 3'd0, 1'b0, MODE_STEADY, 1'b0, 8'hAA}, 1'b0, 8'h00},
      '{'{REQ_SET,    3'd2, 1'b1, MODE_STEADY, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{REQ_UPDATE, 3'd0, 1'b0, MODE_STEADY, 1'b0, 8'h55}, 1'b0, 8'h00},
      '{'{REQ_UPDATE, 3'd0, 1'b0, MODE_STEADY, 1'b0, 8'hFF}, 1'b0, 8'h00}
    };
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_UPDATE;
    req_ch.led_index = '0;
    req_ch.light_value = 1'b0;
    req_ch.blink_mode = MODE_STEADY;
    req_ch.invert_phase = 1'b0;
    req_ch.current_time = '0;
    res_ch.ready = 1'b0;
    rx_wait = $urandom_range(0, 15);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (k = 0; k < SCRIPT_LEN; k++)
      send_req(script[k].rq, script[k].fixed, script[k].fixed_levels);

    for (ph = 0; ph < PHASES; ph++) begin
      drain_to_idle();
      // phase 0 holds every phase forever with all LEDs lit low,
      // phase 1 toggles on any nonzero elapsed time with all LEDs lit high
      apb_write(REG_ON_GEN1, pick_threshold(ph));
      apb_write(REG_OFF_GEN1, pick_threshold(ph));
      apb_write(REG_ON_GEN2, pick_threshold(ph));
      apb_write(REG_OFF_GEN2, pick_threshold(ph));
      apb_write(REG_ON_GEN3, pick_threshold(ph));
      apb_write(REG_OFF_GEN3, pick_threshold(ph));
      apb_write(REG_LEVEL_MSK, (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF :
                               LEVELS_W'($urandom_range(0, 255)));
      apb_write(REG_UNMAPPED, TIME_W'($urandom_range(0, 255)));
      case (ph % 4)
        0: begin tx_max = 15; rx_max = 15; end
        1: begin tx_max = 0;  rx_max = 0;  end
        2: begin tx_max = 0;  rx_max = 15; end
        default: begin tx_max = 15; rx_max = 0; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) send_req(rand_req(), 1'b0, '0);
    end

    drain_to_idle();
    if (mismatch_cnt == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
design/mlb_pkg.sv
design/mlb_if.sv
design/mlb_regs.sv
design/mlb_ctrl.sv
design/mlb_dp.sv
design/multi_led_blink_controller.sv
test/tb_top.sv
